>>> rtl/assert_macros.svh
// Assertion macros shared by the responder RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define MBRH_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define MBRH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MBRH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/mbrh_pkg.sv
// Shared types and constants of the Modbus RTU read-holding responder.
// Used by the controller, the datapath and the top level; no dependencies.
package mbrh_pkg;

  localparam logic       KIND_BYTE = 1'b0;
  localparam logic       KIND_IDLE = 1'b1;

  localparam logic [7:0] FUNC_READ_HOLDING     = 8'h03;
  localparam logic [7:0] FUNC_EXCEPTION_FLAG   = 8'h80;
  localparam logic [7:0] EXC_ILLEGAL_FUNCTION  = 8'h01;
  localparam logic [7:0] EXC_ILLEGAL_ADDRESS   = 8'h02;

  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY_REFL = 16'hA001;

  localparam logic [7:0]  DEVICE_ADDRESS_RESET = 8'd255;
  localparam logic [15:0] GROUP_ONE_BASE_RESET = 16'd1;
  localparam logic [15:0] GROUP_TWO_BASE_RESET = 16'd101;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LOAD,
    ST_CRC
  } mbrh_state_t;

  typedef struct packed {
    logic [7:0]  device_address;
    logic [15:0] group_one_base;
    logic [15:0] group_two_base;
  } mbrh_cfg_t;

  typedef struct packed {
    logic       capture_byte;
    logic       clear_frame;
    logic       start_resp;
    logic       clear_pos;
    logic       incr_pos;
    logic       set_exc;
    logic [7:0] exc_code;
    logic       emit;
    logic       load_out;
    logic       crc_step;
  } mbrh_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic fn_bad;
    logic qty_big;
    logic check_end;
    logic lookup_hit;
    logic is_crc_byte;
    logic is_last_byte;
    logic bit_last;
  } mbrh_status_t;

endpackage

>>> rtl/mbrh_in_if.sv
// Input channel of the responder: received bytes and idle-line events.
// Stand-alone interface; no dependencies.
interface mbrh_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

>>> rtl/mbrh_out_if.sv
// Result channel of the responder: response bytes in send order.
// Stand-alone interface; no dependencies.
interface mbrh_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;

  modport source (output valid, output tx_byte, output last_byte, input ready);
  modport sink   (input valid, input tx_byte, input last_byte, output ready);
endinterface

>>> rtl/mbrh_ctrl.sv
// Controller of the responder: sequences frame capture, range check and byte output.
// Depends on mbrh_pkg; drives the datapath through mbrh_cmd_t.
module mbrh_ctrl
  import mbrh_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_kind,
  output logic         in_ready,
  input  logic         out_ready,
  output logic         out_valid,
  input  mbrh_status_t status,
  output mbrh_cmd_t    cmd
);

  mbrh_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_space;

  assign out_space = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_kind == KIND_IDLE && !status.count_zero) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.fn_bad || status.qty_big || status.check_end || !status.lookup_hit)
          state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_space) begin
          if (status.is_last_byte) state_nxt = ST_IDLE;
          else if (!status.is_crc_byte) state_nxt = ST_CRC;
        end
      end
      ST_CRC: begin
        if (status.bit_last) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == KIND_BYTE) cmd.capture_byte = 1'b1;
          else if (status.count_zero) cmd.clear_frame = 1'b1;
          else cmd.start_resp = 1'b1;
        end
      end
      ST_CHECK: begin
        // one register of the requested range per cycle
        priority if (status.fn_bad) begin
          cmd.set_exc   = 1'b1;
          cmd.exc_code  = EXC_ILLEGAL_FUNCTION;
          cmd.clear_pos = 1'b1;
        end else if (status.qty_big) begin
          cmd.set_exc   = 1'b1;
          cmd.exc_code  = EXC_ILLEGAL_ADDRESS;
          cmd.clear_pos = 1'b1;
        end else if (status.check_end) begin
          cmd.clear_pos = 1'b1;
        end else if (!status.lookup_hit) begin
          cmd.set_exc   = 1'b1;
          cmd.exc_code  = EXC_ILLEGAL_ADDRESS;
          cmd.clear_pos = 1'b1;
        end else begin
          cmd.incr_pos  = 1'b1;
        end
      end
      ST_LOAD: begin
        cmd.emit = 1'b1;
        if (out_space) begin
          cmd.load_out = 1'b1;
          // frame done: drop request fields, go back to taking items
          if (status.is_last_byte) cmd.clear_frame = 1'b1;
          else cmd.incr_pos = 1'b1;
        end
      end
      ST_CRC: begin
        cmd.crc_step = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

endmodule

>>> rtl/mbrh_datapath.sv
// Datapath of the responder: request fields, register lookup, frame byte mux,
// bit-serial CRC-16 and the output register. Depends on mbrh_pkg.
module mbrh_datapath
  import mbrh_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 64,
  parameter int REGS_PER_GROUP  = 5
) (
  input  logic         clk,
  input  logic         rst_n,
  input  mbrh_cfg_t    cfg,
  input  mbrh_cmd_t    cmd,
  input  logic [7:0]   rx_byte,
  output mbrh_status_t status,
  output logic [7:0]   tx_byte,
  output logic         last_byte
);

  localparam int RegCnt = 2 * REGS_PER_GROUP;
  localparam int PosW   = $clog2(2 * RegCnt + 6);
  localparam int CntW   = $clog2(MAX_FRAME_BYTES + 1);

  logic [CntW-1:0] byte_count_r;
  logic [7:0]      function_code_r;
  logic [15:0]     start_address_r;
  logic [15:0]     quantity_r;
  logic [PosW-1:0] pos_r;
  logic            exc_r;
  logic [7:0]      exc_code_r;
  logic [15:0]     crc_r;
  logic [2:0]      bit_cnt_r;
  logic [7:0]      tx_byte_r;
  logic            last_byte_r;

  logic [PosW-1:0] rel;
  logic [PosW-1:0] rsel;
  logic [15:0]     addr;
  logic [15:0]     off1;
  logic [15:0]     off2;
  logic            hit1;
  logic            hit2;
  logic [15:0]     reg_value;
  logic [PosW-1:0] body_len;
  logic [7:0]      frame_byte;
  logic [15:0]     crc_base;

  // register lookup: group one wins where both groups map an address
  assign rel  = pos_r - PosW'(3);
  assign rsel = cmd.emit ? (rel >> 1) : pos_r;
  assign addr = start_address_r + 16'(rsel);
  assign off1 = addr - cfg.group_one_base;
  assign off2 = addr - cfg.group_two_base;
  assign hit1 = off1 < 16'(REGS_PER_GROUP);
  assign hit2 = off2 < 16'(REGS_PER_GROUP);
  assign reg_value = hit1 ? (off1 + 16'd1) : (16'd0 - (off2 + 16'd1));

  assign body_len = exc_r ? PosW'(3) : (PosW'(3) + (PosW'(quantity_r) << 1));

  always_comb begin
    priority if (pos_r == PosW'(0)) begin
      frame_byte = cfg.device_address;
    end else if (pos_r == PosW'(1)) begin
      frame_byte = exc_r ? (function_code_r | FUNC_EXCEPTION_FLAG) : function_code_r;
    end else if (pos_r == PosW'(2)) begin
      frame_byte = exc_r ? exc_code_r : {quantity_r[6:0], 1'b0};
    end else if (pos_r < body_len) begin
      frame_byte = rel[0] ? reg_value[7:0] : reg_value[15:8];
    end else if (pos_r == body_len) begin
      frame_byte = crc_r[7:0];
    end else begin
      frame_byte = crc_r[15:8];
    end
  end

  assign crc_base = (pos_r == PosW'(0)) ? CRC_INIT : crc_r;

  assign status.count_zero   = byte_count_r == CntW'(0);
  assign status.fn_bad       = function_code_r != FUNC_READ_HOLDING;
  assign status.qty_big      = quantity_r > 16'(RegCnt);
  assign status.check_end    = 16'(pos_r) == quantity_r;
  assign status.lookup_hit   = hit1 || hit2;
  assign status.is_crc_byte  = pos_r >= body_len;
  assign status.is_last_byte = pos_r == (body_len + PosW'(1));
  assign status.bit_last     = bit_cnt_r == 3'd7;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r    <= '0;
      function_code_r <= '0;
      start_address_r <= '0;
      quantity_r      <= '0;
      pos_r           <= '0;
      exc_r           <= 1'b0;
    end else begin
      if (cmd.capture_byte) begin
        if (byte_count_r == CntW'(1)) function_code_r <= rx_byte;
        if (byte_count_r == CntW'(2)) start_address_r[15:8] <= rx_byte;
        if (byte_count_r == CntW'(3)) start_address_r[7:0] <= rx_byte;
        if (byte_count_r == CntW'(4)) quantity_r[15:8] <= rx_byte;
        if (byte_count_r == CntW'(5)) quantity_r[7:0] <= rx_byte;
        // saturate at the longest frame
        if (byte_count_r != CntW'(MAX_FRAME_BYTES)) byte_count_r <= byte_count_r + CntW'(1);
      end
      if (cmd.clear_frame) begin
        byte_count_r    <= '0;
        function_code_r <= '0;
        start_address_r <= '0;
        quantity_r      <= '0;
      end
      if (cmd.clear_pos || cmd.start_resp || cmd.clear_frame) pos_r <= '0;
      else if (cmd.incr_pos) pos_r <= pos_r + PosW'(1);
      if (cmd.start_resp || cmd.clear_frame) exc_r <= 1'b0;
      else if (cmd.set_exc) exc_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_exc) exc_code_r <= cmd.exc_code;
    if (cmd.load_out) begin
      tx_byte_r   <= frame_byte;
      last_byte_r <= status.is_last_byte;
      bit_cnt_r   <= 3'd0;
      if (!status.is_crc_byte) crc_r <= crc_base ^ {8'h00, frame_byte};
    end else if (cmd.crc_step) begin
      bit_cnt_r <= bit_cnt_r + 3'd1;
      crc_r     <= crc_r[0] ? ((crc_r >> 1) ^ CRC_POLY_REFL) : (crc_r >> 1);
    end
  end

  assign tx_byte   = tx_byte_r;
  assign last_byte = last_byte_r;

endmodule

>>> rtl/modbus_rtu_read_holding_responder.sv
// Top level of the Modbus RTU read-holding responder: APB registers, controller
// and datapath. Depends on mbrh_pkg, mbrh_in_if, mbrh_out_if, assert_macros.svh.
//
// An idle-line item with a non-empty frame starts the response: the range check
// walks the requested registers one per cycle, then every header and data byte is
// loaded into the output register and followed by the bit-serial CRC update, and
// the two CRC bytes are only loaded, each load waiting while the sink holds
// out_chan.ready low with a byte still pending. The input is not ready while a
// response is being built; it is ready again once the last CRC byte sits in the
// output register.
`include "assert_macros.svh"

module modbus_rtu_read_holding_responder
  import mbrh_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 64,
  parameter int REGS_PER_GROUP  = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  mbrh_in_if.sink     in_chan,
  mbrh_out_if.source  out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_GROUP_ONE_BASE = 2'd1;
  localparam logic [1:0] REG_GROUP_TWO_BASE = 2'd2;

  logic [7:0]   device_address_r;
  logic [15:0]  group_one_base_r;
  logic [15:0]  group_two_base_r;
  logic         cfg_write;
  mbrh_cfg_t    cfg;
  mbrh_cmd_t    cmd;
  mbrh_status_t status;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_address_r <= DEVICE_ADDRESS_RESET;
      group_one_base_r <= GROUP_ONE_BASE_RESET;
      group_two_base_r <= GROUP_TWO_BASE_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_DEVICE_ADDRESS: device_address_r <= pwdata[7:0];
        REG_GROUP_ONE_BASE: group_one_base_r <= pwdata[15:0];
        REG_GROUP_TWO_BASE: group_two_base_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DEVICE_ADDRESS: prdata = {24'h0, device_address_r};
      REG_GROUP_ONE_BASE: prdata = {16'h0, group_one_base_r};
      REG_GROUP_TWO_BASE: prdata = {16'h0, group_two_base_r};
      default:            prdata = 32'h0;
    endcase
  end

  assign cfg.device_address = device_address_r;
  assign cfg.group_one_base = group_one_base_r;
  assign cfg.group_two_base = group_two_base_r;

  mbrh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_kind   (in_chan.kind),
    .in_ready  (in_chan.ready),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .status    (status),
    .cmd       (cmd)
  );

  mbrh_datapath #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .REGS_PER_GROUP  (REGS_PER_GROUP)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .rx_byte   (in_chan.rx_byte),
    .status    (status),
    .tx_byte   (out_chan.tx_byte),
    .last_byte (out_chan.last_byte)
  );

  `MBRH_ASSERT_IMP(a_no_overwrite, cmd.load_out, !out_chan.valid || out_chan.ready, "pending item overwritten")
  `MBRH_ASSERT_IMP(a_capture_on_accept, cmd.capture_byte, in_chan.valid && in_chan.ready, "byte captured without accept")
  `MBRH_ASSERT_NEXT(a_ready_after_last, cmd.load_out && status.is_last_byte, in_chan.ready, "input not reopened after last byte")
  `MBRH_ASSERT_ALWAYS(a_busy_blocks_input, !(cmd.crc_step && in_chan.ready), "input ready during CRC update")

endmodule
